// ----- rtl/sobel_edge_magnitude_macros.svh -----
// Assertion helpers shared by the sobel edge magnitude RTL.
// Simulation builds get concurrent assertions; synthesis builds get nothing.
`ifndef SOBEL_EDGE_MAGNITUDE_MACROS_SVH
`define SOBEL_EDGE_MAGNITUDE_MACROS_SVH

`ifndef SYNTHESIS

// Antecedent must imply the consequent in the same cycle.
`define SME_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Antecedent must imply the consequent in the next cycle.
`define SME_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define SME_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define SME_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// ----- rtl/sme_pkg.sv -----
package sme_pkg;

	localparam int PIX_W        = 8;
	localparam int MAX_WIDTH    = 1024;
	localparam int COL_W        = $clog2(MAX_WIDTH);
	localparam int ROW_W        = 12;
	localparam int WREG_W       = 11;
	localparam int HREG_W       = 13;
	localparam int HEIGHT_LIMIT = 4096;
	localparam int MIN_DIM      = 3;
	localparam int GRAD_W       = 12;
	localparam int EDGE_SAT     = 255;
	localparam int CFG_IDX_W    = 8;
	localparam int CFG_DATA_W   = 16;
	// One line store entry holds a pixel of row y-1 and one of row y-2.
	localparam int LS_W         = 2 * PIX_W;

	localparam logic [WREG_W-1:0] WIDTH_RESET  = WREG_W'(1024);
	localparam logic [HREG_W-1:0] HEIGHT_RESET = HREG_W'(1024);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_WIDTH  = 8'd0,
		REG_IMAGE_HEIGHT = 8'd1
	} reg_index_t;

	typedef logic [PIX_W-1:0] pixel_t;

	// One column of the 3x3 window, top row first.
	typedef struct packed {
		pixel_t top;
		pixel_t mid;
		pixel_t bot;
	} column_t;

	// Raster position of the pixel offered at the input.
	typedef struct packed {
		logic [COL_W-1:0] col;
		logic             produce;
		logic             last;
	} raster_pos_t;

	// Per-pixel control carried alongside stage 1.
	typedef struct packed {
		logic produce;
		logic last;
	} item_ctl_t;

	function automatic logic signed [GRAD_W-1:0] pix_ext(input pixel_t p);
		pix_ext = $signed({{(GRAD_W-PIX_W){1'b0}}, p});
	endfunction

endpackage

// ----- rtl/sobel_edge_magnitude.sv -----
// Sobel 3x3 edge detector with L1 magnitude. Pixels enter in raster order on the
// slave stream, one request per clock at full rate; each interior center pixel
// yields one 8-bit result, |Gx|+|Gy| saturated at 255, and border centers yield
// nothing. The result for center (x-1, y-1) is computed when the pixel at (x, y)
// leaves stage 1 and waits in the output register until taken; tlast marks the
// last result of a frame. The rate is one pixel per clock while the output is not
// stalled: a pixel reads its column of the two previous rows from one 1024-deep,
// 16-bit line store on the edge it is taken and writes the shifted column back on
// the edge it leaves stage 1, so one read and one write port serve every cycle.
// Input tready drops only while stage 1 holds a pixel that has a result and the
// output register holds an untaken one. The line store has no clearing pass after
// reset; its contents matter only once a full row has been written. Image width
// and height must be written on the configuration channel only between frames,
// which the block does not enforce; the raster counters wrap at each frame's end.
`include "sobel_edge_magnitude_macros.svh"

module sobel_edge_magnitude (
	input  logic                           clk,
	input  logic                           arst_n,
	// Configuration write channel.
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [sme_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [sme_pkg::CFG_DATA_W-1:0] cfg_data,
	// Pixel input stream.
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	input  logic [7:0]                     s_axis_tdata,  // [7:0] pixel_in
	// Edge result stream.
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	output logic [7:0]                     m_axis_tdata,  // [7:0] edge_value
	output logic                           m_axis_tlast   // frame_last
);
	import sme_pkg::*;

	logic [WREG_W-1:0] width_q;
	logic [HREG_W-1:0] height_q;

	raster_pos_t       pos;
	logic              in_acc;
	logic              adv_s1;

	logic              valid_s1;
	pixel_t            pix_s1;
	logic [COL_W-1:0]  col_s1;
	item_ctl_t         ctl_s1;
	logic [LS_W-1:0]   ls_rd;
	column_t           new_col;

	// Configuration registers. Writes to unknown indexes are dropped.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_IMAGE_WIDTH:  width_q  <= cfg_data[WREG_W-1:0];
				REG_IMAGE_HEIGHT: height_q <= cfg_data[HREG_W-1:0];
				default: ;
			endcase
		end
	end

	// Stage 1 moves on unless it carries a result that the full output
	// register cannot yet take. Border pixels never wait on the output.
	assign adv_s1        = valid_s1 && (!ctl_s1.produce || !m_axis_tvalid || m_axis_tready);
	assign s_axis_tready = !valid_s1 || adv_s1;
	assign in_acc        = s_axis_tvalid && s_axis_tready;

	sme_raster u_raster (
		.clk          (clk),
		.arst_n       (arst_n),
		.advance      (in_acc),
		.image_width  (width_q),
		.image_height (height_q),
		.pos          (pos)
	);

	// Each entry holds row y-1 in the upper byte and row y-2 in the lower byte.
	sme_line_store #(
		.DEPTH (MAX_WIDTH),
		.WIDTH (LS_W)
	) u_line_store (
		.clk     (clk),
		.rd_en   (in_acc),
		.rd_addr (pos.col),
		.rd_data (ls_rd),
		.wr_en   (adv_s1),
		.wr_addr (col_s1),
		.wr_data ({pix_s1, ls_rd[LS_W-1:PIX_W]})
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			pix_s1         <= s_axis_tdata[PIX_W-1:0];
			col_s1         <= pos.col;
			ctl_s1.produce <= pos.produce;
			ctl_s1.last    <= pos.last;
		end
	end

	assign new_col.top = ls_rd[PIX_W-1:0];
	assign new_col.mid = ls_rd[LS_W-1:PIX_W];
	assign new_col.bot = pix_s1;

	sme_grad u_grad (
		.clk        (clk),
		.arst_n     (arst_n),
		.advance    (adv_s1),
		.new_col    (new_col),
		.ctl        (ctl_s1),
		.out_ready  (m_axis_tready),
		.out_valid  (m_axis_tvalid),
		.edge_value (m_axis_tdata),
		.frame_last (m_axis_tlast)
	);

	// The write-back of one pixel and the read for the next never share an address.
	`SME_ASSERT_IMP(a_line_store_no_clash, clk, arst_n, in_acc && adv_s1,
		pos.col != col_s1, "line store read and write hit the same column")
	// A taken pixel always sits in stage 1 on the following cycle.
	`SME_ASSERT_NXT(a_accept_fills_s1, clk, arst_n, in_acc,
		valid_s1, "accepted pixel missing from stage 1")
	// A result-bearing pixel leaving stage 1 always lands in the output register.
	`SME_ASSERT_NXT(a_result_lands, clk, arst_n, adv_s1 && ctl_s1.produce,
		m_axis_tvalid, "result lost between stage 1 and output")

endmodule

// ----- rtl/sme_line_store.sv -----
module sme_line_store #(
	parameter int DEPTH  = 1024,
	parameter int WIDTH  = 16,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [WIDTH-1:0]  rd_data,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [WIDTH-1:0]  wr_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ----- rtl/sme_raster.sv -----
module sme_raster (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       advance,
	input  logic [sme_pkg::WREG_W-1:0] image_width,
	input  logic [sme_pkg::HREG_W-1:0] image_height,
	output sme_pkg::raster_pos_t       pos
);
	import sme_pkg::*;

	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic [WREG_W-1:0] eff_w;
	logic [HREG_W-1:0] eff_h;
	logic              end_col;
	logic              end_row;

	// Out-of-range settings are clamped to the legal span.
	always_comb begin
		if (image_width < WREG_W'(MIN_DIM)) begin
			eff_w = WREG_W'(MIN_DIM);
		end else if (image_width > WREG_W'(MAX_WIDTH)) begin
			eff_w = WREG_W'(MAX_WIDTH);
		end else begin
			eff_w = image_width;
		end
		if (image_height < HREG_W'(MIN_DIM)) begin
			eff_h = HREG_W'(MIN_DIM);
		end else if (image_height > HREG_W'(HEIGHT_LIMIT)) begin
			eff_h = HREG_W'(HEIGHT_LIMIT);
		end else begin
			eff_h = image_height;
		end
	end

	assign end_col = (WREG_W'(col_q) + WREG_W'(1)) >= eff_w;
	assign end_row = (HREG_W'(row_q) + HREG_W'(1)) >= eff_h;

	assign pos.col     = col_q;
	assign pos.produce = (col_q >= COL_W'(2)) && (row_q >= ROW_W'(2));
	assign pos.last    = end_col && end_row;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (advance) begin
			if (end_col) begin
				col_q <= '0;
				row_q <= end_row ? '0 : row_q + ROW_W'(1);
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

endmodule

// ----- rtl/sme_grad.sv -----
module sme_grad (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   advance,
	input  sme_pkg::column_t       new_col,
	input  sme_pkg::item_ctl_t     ctl,
	input  logic                   out_ready,
	output logic                   out_valid,
	output logic [sme_pkg::PIX_W-1:0] edge_value,
	output logic                   frame_last
);
	import sme_pkg::*;

	column_t                   left_q;
	column_t                   mid_q;
	logic signed [GRAD_W-1:0]  gx;
	logic signed [GRAD_W-1:0]  gy;
	logic        [GRAD_W-1:0]  abs_gx;
	logic        [GRAD_W-1:0]  abs_gy;
	logic        [GRAD_W-1:0]  mag;
	pixel_t                    mag_sat;
	logic                      valid_s2;
	pixel_t                    edge_s2;
	logic                      last_s2;

	// Window after the shift: left_q, mid_q, new_col from left to right.
	always_comb begin
		gx = (pix_ext(new_col.top) - pix_ext(left_q.top))
		   + ((pix_ext(new_col.mid) - pix_ext(left_q.mid)) <<< 1)
		   + (pix_ext(new_col.bot) - pix_ext(left_q.bot));
		gy = (pix_ext(left_q.bot) - pix_ext(left_q.top))
		   + ((pix_ext(mid_q.bot) - pix_ext(mid_q.top)) <<< 1)
		   + (pix_ext(new_col.bot) - pix_ext(new_col.top));
		abs_gx  = gx[GRAD_W-1] ? GRAD_W'(-gx) : GRAD_W'(gx);
		abs_gy  = gy[GRAD_W-1] ? GRAD_W'(-gy) : GRAD_W'(gy);
		mag     = abs_gx + abs_gy;
		mag_sat = (mag > GRAD_W'(EDGE_SAT)) ? PIX_W'(EDGE_SAT) : mag[PIX_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= '0;
			mid_q  <= '0;
		end else if (advance) begin
			left_q <= mid_q;
			mid_q  <= new_col;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance && ctl.produce) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && ctl.produce) begin
			edge_s2 <= mag_sat;
			last_s2 <= ctl.last;
		end
	end

	assign out_valid  = valid_s2;
	assign edge_value = edge_s2;
	assign frame_last = last_s2;

endmodule
